[rtl/stt_pkg.sv]
// Shared types and constants for the sleep timer table.
// No dependencies; used by stt_mul_div and sleep_timer_table.
package stt_pkg;

	localparam int ID_W        = 16;
	localparam int MS_W        = 32;
	localparam int RATE_W      = 16;
	localparam int REM_W       = 40;
	localparam int PROD_W      = MS_W + RATE_W;
	localparam int EV_W        = 2;
	localparam int MS_PER_SEC  = 1000;
	localparam int DEPTH_DEF   = 16;
	localparam int MUL_W       = 32;

	// ceil(2^38 / 1000): floor(x * RECIP_MS / 2^38) == floor(x / 1000) for any 32-bit x
	localparam logic [MUL_W-1:0] RECIP_MS = 32'd274877907;
	localparam int               RECIP_SH = 38;

	localparam logic [RATE_W-1:0] RATE_RESET = 16'd18;

	localparam logic [EV_W-1:0] EV_WAKE   = 2'd0;
	localparam logic [EV_W-1:0] EV_ACCEPT = 2'd1;
	localparam logic [EV_W-1:0] EV_FULL   = 2'd2;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_SLEEP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SRCH,
		ST_RESP,
		ST_TICK,
		ST_TFLUSH
	} state_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_QUOT,
		MD_REM,
		MD_HIGH,
		MD_LOW,
		MD_FRAC
	} md_state_t;

endpackage

[rtl/stt_mul_div.sv]
// Converts milliseconds to ticks on one shared 32x32 multiplier in five steps:
// ms/1000 by reciprocal, its remainder, both parts times the rate, then the
// remainder part over 1000 by reciprocal again. Uses stt_pkg.
module stt_mul_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stt_pkg::MS_W-1:0]    ms,
	input  logic [stt_pkg::RATE_W-1:0]  rate,
	output logic                        done,
	output logic [stt_pkg::REM_W-1:0]   quot
);

	localparam int QMS_W = 23;   // ms / 1000
	localparam int RMS_W = 10;   // ms % 1000
	localparam int LOW_W = 26;   // (ms % 1000) * rate
	localparam int FRC_W = 16;   // that over 1000

	stt_pkg::md_state_t state_q, state_d;

	logic [stt_pkg::MS_W-1:0]    ms_q;
	logic [stt_pkg::RATE_W-1:0]  rate_q;
	logic [QMS_W-1:0]            qms_q;
	logic [RMS_W-1:0]            rms_q;
	logic [LOW_W-1:0]            low_q;
	logic [stt_pkg::REM_W-1:0]   acc_q;
	logic [stt_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [2*stt_pkg::MUL_W-1:0] mul_p;
	logic [stt_pkg::MS_W-1:0]    back;

	assign mul_p = mul_a * mul_b;
	assign back  = ms_q - mul_p[stt_pkg::MS_W-1:0];
	assign done  = (state_q == stt_pkg::MD_FRAC);
	assign quot  = acc_q;

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			stt_pkg::MD_IDLE: begin
				state_d = stt_pkg::MD_IDLE;
			end
			stt_pkg::MD_QUOT: begin
				mul_a   = ms_q;
				mul_b   = stt_pkg::RECIP_MS;
				state_d = stt_pkg::MD_REM;
			end
			stt_pkg::MD_REM: begin
				mul_a   = stt_pkg::MUL_W'(qms_q);
				mul_b   = stt_pkg::MUL_W'(stt_pkg::MS_PER_SEC);
				state_d = stt_pkg::MD_HIGH;
			end
			stt_pkg::MD_HIGH: begin
				mul_a   = stt_pkg::MUL_W'(qms_q);
				mul_b   = stt_pkg::MUL_W'(rate_q);
				state_d = stt_pkg::MD_LOW;
			end
			stt_pkg::MD_LOW: begin
				mul_a   = stt_pkg::MUL_W'(rms_q);
				mul_b   = stt_pkg::MUL_W'(rate_q);
				state_d = stt_pkg::MD_FRAC;
			end
			stt_pkg::MD_FRAC: begin
				mul_a   = stt_pkg::MUL_W'(low_q);
				mul_b   = stt_pkg::RECIP_MS;
				state_d = stt_pkg::MD_IDLE;
			end
			default: begin
				state_d = stt_pkg::MD_IDLE;
			end
		endcase
		if (start) begin
			state_d = stt_pkg::MD_QUOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ms_q   <= ms;
			rate_q <= rate;
		end
		case (state_q)
			stt_pkg::MD_QUOT: begin
				qms_q <= mul_p[stt_pkg::RECIP_SH+QMS_W-1:stt_pkg::RECIP_SH];
			end
			stt_pkg::MD_REM: begin
				rms_q <= back[RMS_W-1:0];
			end
			stt_pkg::MD_HIGH: begin
				acc_q <= mul_p[stt_pkg::REM_W-1:0];
			end
			stt_pkg::MD_LOW: begin
				low_q <= mul_p[LOW_W-1:0];
			end
			stt_pkg::MD_FRAC: begin
				acc_q <= acc_q
				       + stt_pkg::REM_W'(mul_p[stt_pkg::RECIP_SH+FRC_W-1:stt_pkg::RECIP_SH]);
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/sleep_timer_table.sv]
// Sleep timer table top level: sequencer, entry table and output register.
// Depends on stt_pkg and stt_mul_div.
//
//  group   dir  signals                     word
//  s_      in   tvalid tready tdata tuser   tdata: process_id, sleep_ms; tuser: kind
//  m_      out  tvalid tready tdata tuser   tdata: woken_id; tuser: event_res; tlast
//  cfg_    in   we wdata                    tick_rate_hz
//
// After a request is accepted, s_tready stays low until its work is done:
// sleep request: the five multiply steps, a search of the table, then the response word.
// Tick: a walk over every entry, then a flush of the held wake; output stalls extend both.
// s_tready is high only while idle. Reset leaves the table empty, no clearing pass.
// A wake waits in a holding register until the next one is found or the walk ends, so tlast is known.
module sleep_timer_table #(
	parameter int TABLE_DEPTH = stt_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,   // process_id, sleep_ms
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [stt_pkg::ID_W-1:0]      m_tdata,   // woken_id
	output logic [stt_pkg::EV_W-1:0]      m_tuser,   // event_res
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [stt_pkg::RATE_W-1:0]    cfg_wdata
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	stt_pkg::state_t state_q, state_d;

	logic [stt_pkg::RATE_W-1:0] rate_q;
	logic [stt_pkg::ID_W-1:0]   pid_q;
	logic [stt_pkg::EV_W-1:0]   ev_q, ev_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [CNT_W-1:0]           i_q, i_d;
	logic [CNT_W-1:0]           keep_q, keep_d;
	logic                       pend_v_q, pend_v_d;
	logic [stt_pkg::ID_W-1:0]   pend_id_q, pend_id_d;

	logic [stt_pkg::ID_W-1:0]   tbl_id  [TABLE_DEPTH];
	logic [stt_pkg::REM_W-1:0]  tbl_rem [TABLE_DEPTH];
	logic [IDX_W-1:0]           rd_idx;
	logic [stt_pkg::ID_W-1:0]   rd_id_q;
	logic [stt_pkg::REM_W-1:0]  rd_rem_q;

	logic                       wr_en;
	logic [IDX_W-1:0]           wr_idx;
	logic [stt_pkg::ID_W-1:0]   wr_id;
	logic [stt_pkg::REM_W-1:0]  wr_rem;

	logic                       out_free, out_load, out_last;
	logic [stt_pkg::EV_W-1:0]   out_ev;
	logic [stt_pkg::ID_W-1:0]   out_id;
	logic                       m_tvalid_q, m_tlast_q;
	logic [stt_pkg::EV_W-1:0]   m_tuser_q;
	logic [stt_pkg::ID_W-1:0]   m_tdata_q;

	logic                       accept, div_start, div_done;
	logic [stt_pkg::REM_W-1:0]  ticks;

	assign s_tready  = (state_q == stt_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign div_start = accept && (s_tuser == stt_pkg::KIND_SLEEP);
	assign out_free  = !m_tvalid_q || m_tready;
	assign rd_idx    = i_d[IDX_W-1:0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	stt_mul_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.ms     (s_tdata[47:16]),
		.rate   (rate_q),
		.done   (div_done),
		.quot   (ticks)
	);

	always_comb begin
		state_d   = state_q;
		ev_d      = ev_q;
		count_d   = count_q;
		i_d       = i_q;
		keep_d    = keep_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		wr_en     = 1'b0;
		wr_idx    = i_q[IDX_W-1:0];
		wr_id     = rd_id_q;
		wr_rem    = ticks;
		out_load  = 1'b0;
		out_ev    = stt_pkg::EV_WAKE;
		out_id    = pend_id_q;
		out_last  = 1'b0;
		case (state_q)
			stt_pkg::ST_IDLE: begin
				i_d      = '0;
				keep_d   = '0;
				pend_v_d = 1'b0;
				if (accept) begin
					state_d = (s_tuser == stt_pkg::KIND_SLEEP) ? stt_pkg::ST_DIV
					                                           : stt_pkg::ST_TICK;
				end
			end
			stt_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = stt_pkg::ST_SRCH;
				end
			end
			stt_pkg::ST_SRCH: begin
				if (i_q == count_q) begin
					state_d = stt_pkg::ST_RESP;
					if (count_q == CNT_W'(TABLE_DEPTH)) begin
						ev_d = stt_pkg::EV_FULL;
					end else begin
						ev_d    = stt_pkg::EV_ACCEPT;
						wr_en   = 1'b1;
						wr_idx  = count_q[IDX_W-1:0];
						wr_id   = pid_q;
						count_d = count_q + 1'b1;
					end
				end else if (rd_id_q == pid_q) begin
					state_d = stt_pkg::ST_RESP;
					ev_d    = stt_pkg::EV_ACCEPT;
					wr_en   = 1'b1;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			stt_pkg::ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_ev   = ev_q;
					out_id   = pid_q;
					out_last = 1'b1;
					state_d  = stt_pkg::ST_IDLE;
				end
			end
			stt_pkg::ST_TICK: begin
				if (i_q == count_q) begin
					state_d = stt_pkg::ST_TFLUSH;
				end else if (rd_rem_q <= stt_pkg::REM_W'(1)) begin
					if (!pend_v_q) begin
						pend_v_d  = 1'b1;
						pend_id_d = rd_id_q;
						i_d       = i_q + 1'b1;
					end else if (out_free) begin
						out_load  = 1'b1;
						pend_id_d = rd_id_q;
						i_d       = i_q + 1'b1;
					end
				end else begin
					wr_en  = 1'b1;
					wr_idx = keep_q[IDX_W-1:0];
					wr_rem = rd_rem_q - 1'b1;
					keep_d = keep_q + 1'b1;
					i_d    = i_q + 1'b1;
				end
			end
			stt_pkg::ST_TFLUSH: begin
				count_d = keep_q;
				if (!pend_v_q) begin
					state_d = stt_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					pend_v_d = 1'b0;
					state_d  = stt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= stt_pkg::ST_IDLE;
			rate_q     <= stt_pkg::RATE_RESET;
			count_q    <= '0;
			i_q        <= '0;
			keep_q     <= '0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			i_q      <= i_d;
			keep_q   <= keep_d;
			pend_v_q <= pend_v_d;
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_q      <= ev_d;
		pend_id_q <= pend_id_d;
		if (accept) begin
			pid_q <= s_tdata[15:0];
		end
		if (out_load) begin
			m_tdata_q <= out_id;
			m_tuser_q <= out_ev;
			m_tlast_q <= out_last;
		end
	end

	// entry store, no reset: only entries below the count are read
	// read one entry ahead; compaction writes only land below the next index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_id[wr_idx]  <= wr_id;
			tbl_rem[wr_idx] <= wr_rem;
		end
		rd_id_q  <= tbl_id[rd_idx];
		rd_rem_q <= tbl_rem[rd_idx];
	end

endmodule

[sim/tb_top.sv]
// Testbench for sleep_timer_table: directed and random sleep requests and ticks.
// Holds a scoreboard class that predicts the wake, accept and full words in order.
// Depends on stt_pkg and the sleep_timer_table RTL.
module tb_top;
	import stt_pkg::*;

	localparam int SLOTS      = DEPTH_DEF;
	localparam int DRAIN_WAIT = 120;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 400;

	typedef struct packed {
		logic [EV_W-1:0] ev;
		logic [ID_W-1:0] id;
		logic            last;
	} timer_word_t;

	class timer_scoreboard;
		logic [ID_W-1:0]   ids[SLOTS];
		logic [REM_W-1:0]  remaining[SLOTS];
		int unsigned       count;
		logic [RATE_W-1:0] rate;
		timer_word_t       expected_q[$];
		int unsigned       errors;

		function new();
			count = 0;
			rate = RATE_RESET;
			errors = 0;
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void push_word(logic [EV_W-1:0] ev, logic [ID_W-1:0] id, logic last);
			timer_word_t w;
			w.ev = ev;
			w.id = id;
			w.last = last;
			expected_q.push_back(w);
		endfunction

		// one accepted input word
		function void note_word(logic kind, logic [ID_W-1:0] pid, logic [MS_W-1:0] ms);
			logic [PROD_W-1:0] product;
			logic [REM_W-1:0]  ticks;
			logic [ID_W-1:0]   woken[$];
			int unsigned       keep;
			bit                hit;
			if (kind == KIND_SLEEP) begin
				product = PROD_W'(ms) * PROD_W'(rate);
				ticks = REM_W'(product / MS_PER_SEC);
				hit = 0;
				for (int i = 0; i < count; i++) begin
					if (!hit && ids[i] == pid) begin
						remaining[i] = ticks;
						hit = 1;
					end
				end
				if (hit) begin
					push_word(EV_ACCEPT, pid, 1'b1);
				end else if (count >= SLOTS) begin
					push_word(EV_FULL, pid, 1'b1);
				end else begin
					ids[count] = pid;
					remaining[count] = ticks;
					count++;
					push_word(EV_ACCEPT, pid, 1'b1);
				end
			end else begin
				keep = 0;
				for (int i = 0; i < count; i++) begin
					if (remaining[i] <= 1) begin
						woken.push_back(ids[i]);
					end else begin
						ids[keep] = ids[i];
						remaining[keep] = remaining[i] - 1;
						keep++;
					end
				end
				count = keep;
				for (int j = 0; j < woken.size(); j++)
					push_word(EV_WAKE, woken[j], j == woken.size() - 1);
			end
		endfunction

		function void check_word(logic [EV_W-1:0] ev, logic [ID_W-1:0] id, logic last);
			timer_word_t w;
			if (expected_q.size() == 0) begin
				fail($sformatf("unexpected word: ev=%0d id=%h last=%b", ev, id, last));
				return;
			end
			w = expected_q.pop_front();
			if (w.ev !== ev || w.id !== id || w.last !== last)
				fail($sformatf({"word mismatch: expected ev=%0d id=%h last=%b, ",
					"got ev=%0d id=%h last=%b"},
					w.ev, w.id, w.last, ev, id, last));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [47:0]         s_tdata = '0;   // process_id, sleep_ms
	logic                s_tuser = 1'b0; // kind
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [ID_W-1:0]     m_tdata;        // woken_id
	logic [EV_W-1:0]     m_tuser;        // event_res
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [RATE_W-1:0]   cfg_wdata = '0;

	timer_scoreboard sb;
	bit              long_hold_req = 0;
	int unsigned     burst_left = 0;
	int unsigned     idle_cycles = 0;

	sleep_timer_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: own stall pattern plus one long hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_word(m_tuser, m_tdata, m_tlast);
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0, 1: m_tready <= 1'b1;
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(logic kind, logic [ID_W-1:0] pid, logic [MS_W-1:0] ms);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {ms, pid};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_word(kind, pid, ms);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	task automatic set_rate(logic [RATE_W-1:0] value);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// a tick that wakes nobody may still be walking the table
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.rate = value;
	endtask

	// duration landing near a small tick count at the current rate
	function automatic logic [MS_W-1:0] short_ms();
		int unsigned t;
		if (sb.rate == 0)
			return $urandom_range(0, 5000);
		t = $urandom_range(0, 12);
		return (t * 1000) / sb.rate + $urandom_range(0, 1000 / sb.rate);
	endfunction

	task automatic random_word();
		logic [ID_W-1:0] pid;
		logic [MS_W-1:0] ms;
		int unsigned     pick;
		if ($urandom_range(0, 99) < 45) begin
			send_word(KIND_TICK, ID_W'($urandom), $urandom);
			return;
		end
		if (sb.count > 0 && $urandom_range(0, 2) == 0)
			pid = sb.ids[$urandom_range(0, sb.count - 1)];
		else
			pid = ID_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 75)
			ms = short_ms();
		else if (pick < 90)
			ms = $urandom_range(0, 1 << 20);
		else
			ms = $urandom;
		send_word(KIND_SLEEP, pid, ms);
	endtask

	initial begin : stimulus
		logic [RATE_W-1:0] rates[5];
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset rate
		send_word(KIND_TICK, 16'h0000, 32'h0);
		send_word(KIND_SLEEP, 16'h0000, 32'd0);
		send_word(KIND_SLEEP, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(KIND_SLEEP, 16'h1234, 32'd112);
		send_word(KIND_SLEEP, 16'h0000, 32'd56);
		send_word(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(KIND_TICK, 16'h0000, 32'h0);
		for (int i = 1; i < SLOTS; i++)
			send_word(KIND_SLEEP, ID_W'(i), 32'd0);
		send_word(KIND_SLEEP, 16'hAAAA, 32'd1000);
		send_word(KIND_TICK, 16'h5555, 32'h5555_5555);
		send_word(KIND_SLEEP, 16'hFFFF, 32'd0);
		send_word(KIND_TICK, 16'hAAAA, 32'hAAAA_AAAA);

		rates[0] = 16'd0;
		rates[1] = 16'd1;
		rates[2] = 16'hFFFF;
		rates[3] = RATE_W'($urandom_range(2, 65534));
		rates[4] = 16'd1000;
		foreach (rates[p]) begin
			set_rate(rates[p]);
			for (int n = 0; n < 39; n++) begin
				if (p == 4 && n == 10)
					long_hold_req = 1;
				random_word();
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[sleep_timer_table.f]
rtl/stt_pkg.sv
rtl/stt_mul_div.sv
rtl/sleep_timer_table.sv
sim/tb_top.sv
